// ----- src/m4mul_pkg.sv -----
// Shared types and constants for the 4x4 fixed-point matrix multiply unit.
package m4mul_pkg;

   // Sequencer states of the top level.
   typedef enum logic [1:0] {
      ST_LOAD,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } seq_state_type;

   // Control from the sequencer to the shared multiply-accumulate unit.
   typedef struct packed {
      logic clear;   // start a new sum
      logic valid;   // operand pair present this cycle
   } mac_ctl_type;

   // Last value of the drain counter, waiting for the read, multiply and accumulate registers.
   localparam logic [1:0] DRAIN_LAST = 2'd2;

   // Field widths of the streaming ports.
   localparam int ELEM_BITS     = 32;
   localparam int INDEX_BITS    = 2;
   localparam int RSP_DATA_BITS = 40;

endpackage

// ----- src/matrix4_multiply_unit.sv -----
// Top level of the fixed-point matrix multiply unit: operand stores and sequencer.
// Loading takes one element per cycle while req_tvalid is high, 2*DIM*DIM transactions, ready throughout.
// Each product element is then formed on the one shared multiply-accumulate
// unit, through read, multiply, accumulate and saturate, and is held until
// taken; no input is taken while a full product is formed.
// Synchronous active-high reset returns the sequencer to loading with no result pending.
module matrix4_multiply_unit #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                                  clock,
   input  logic                                  reset,
   // req_tdata: element [31:0]
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [m4mul_pkg::ELEM_BITS-1:0]       req_tdata,
   // rsp_tdata: product [31:0], row_index [33:32], col_index [35:34], zeros [39:36]
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [m4mul_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // rsp_tuser: overflow [0]
   output logic                                  rsp_tuser,
   output logic                                  rsp_tlast
);
   import m4mul_pkg::*;

   localparam int CELLS  = DIM * DIM;
   localparam int CELL_W = $clog2(CELLS);
   localparam int LOAD_W = $clog2(2 * CELLS);
   localparam int DIM_W  = $clog2(DIM);

   localparam logic [LOAD_W-1:0] CELLS_C     = LOAD_W'(CELLS);
   localparam logic [LOAD_W-1:0] LOAD_LAST   = LOAD_W'(2 * CELLS - 1);
   localparam logic [DIM_W-1:0]  DIM_LAST    = DIM_W'(DIM - 1);
   localparam logic [CELL_W-1:0] DIM_C       = CELL_W'(DIM);
   localparam logic [ELEM_BITS-1:0] SAT_MAX32 =
      ELEM_BITS'((64'd1 << (WORD_BITS - 1)) - 64'd1);
   localparam logic [ELEM_BITS-1:0] SAT_MIN32 = ~SAT_MAX32;

   seq_state_type state_ff, state_in;
   logic [LOAD_W-1:0] load_cnt_ff, load_cnt_in;
   logic [DIM_W-1:0]  row_ff, row_in;
   logic [DIM_W-1:0]  col_ff, col_in;
   logic [DIM_W-1:0]  k_ff, k_in;
   logic [1:0]        drain_ff, drain_in;
   logic              rd_vld_ff;
   logic              wr_left;
   logic              wr_right;
   logic              issue;
   logic              out_load;
   mac_ctl_type       mac_ctl;

   logic [WORD_BITS-1:0] left_mem  [CELLS];
   logic [WORD_BITS-1:0] right_mem [CELLS];
   logic [WORD_BITS-1:0] elem;
   logic [CELL_W-1:0]    left_waddr;
   logic [CELL_W-1:0]    right_waddr;
   logic [CELL_W-1:0]    a_addr;
   logic [CELL_W-1:0]    b_addr;
   logic signed [WORD_BITS-1:0] a_q_ff;
   logic signed [WORD_BITS-1:0] b_q_ff;

   logic signed [WORD_BITS-1:0] sat_value;
   logic                        sat_overflow;
   logic signed [WORD_BITS-1:0] rsp_value_ff;
   logic                        rsp_ovf_ff;
   logic [DIM_W-1:0]            rsp_row_ff;
   logic [DIM_W-1:0]            rsp_col_ff;
   logic                        rsp_last_ff;

   // Only the low word bits of an element take part.
   assign elem        = req_tdata[WORD_BITS-1:0];
   assign left_waddr  = load_cnt_ff[CELL_W-1:0];
   assign right_waddr = CELL_W'(load_cnt_ff - CELLS_C);
   assign a_addr      = CELL_W'(row_ff) * DIM_C + CELL_W'(k_ff);
   assign b_addr      = CELL_W'(k_ff) * DIM_C + CELL_W'(col_ff);

   // Operand stores: one write port for loading, one registered read port each.
   always_ff @(posedge clock) begin
      if (wr_left) begin
         left_mem[left_waddr] <= elem;
      end
      if (wr_right) begin
         right_mem[right_waddr] <= elem;
      end
      a_q_ff <= left_mem[a_addr];
      b_q_ff <= right_mem[b_addr];
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         load_cnt_ff <= '0;
         row_ff      <= '0;
         col_ff      <= '0;
         k_ff        <= '0;
         drain_ff    <= '0;
         rd_vld_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         load_cnt_ff <= load_cnt_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         k_ff        <= k_in;
         drain_ff    <= drain_in;
         rd_vld_ff   <= issue;
      end
   end

   // Next state and control of the sequencer.
   always_comb begin
      state_in    = state_ff;
      load_cnt_in = load_cnt_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      k_in        = k_ff;
      drain_in    = drain_ff;
      wr_left     = 1'b0;
      wr_right    = 1'b0;
      issue       = 1'b0;
      out_load    = 1'b0;
      mac_ctl     = '0;
      case (state_ff)
         ST_LOAD: begin
            if (req_tvalid) begin
               wr_left  = (load_cnt_ff < CELLS_C);
               wr_right = ~(load_cnt_ff < CELLS_C);
               if (load_cnt_ff == LOAD_LAST) begin
                  load_cnt_in = '0;
                  row_in      = '0;
                  col_in      = '0;
                  k_in        = '0;
                  state_in    = ST_MAC;
               end else begin
                  load_cnt_in = load_cnt_ff + 1'b1;
               end
            end
         end
         ST_MAC: begin
            issue         = 1'b1;
            mac_ctl.clear = (k_ff == '0);
            if (k_ff == DIM_LAST) begin
               k_in     = '0;
               drain_in = '0;
               state_in = ST_DRAIN;
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == DRAIN_LAST) begin
               out_load = 1'b1;
               state_in = ST_OUT;
            end else begin
               drain_in = drain_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (rsp_tready) begin
               state_in = ST_MAC;
               if (col_ff == DIM_LAST) begin
                  col_in = '0;
                  if (row_ff == DIM_LAST) begin
                     row_in   = '0;
                     state_in = ST_LOAD;
                  end else begin
                     row_in = row_ff + 1'b1;
                  end
               end else begin
                  col_in = col_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
      mac_ctl.valid = rd_vld_ff;
   end

   assign req_tready = (state_ff == ST_LOAD);

   m4mul_mac #(
      .DIM       (DIM),
      .FRAC_BITS (FRAC_BITS),
      .WORD_BITS (WORD_BITS)
   ) u_mac (
      .clock        (clock),
      .reset        (reset),
      .ctl          (mac_ctl),
      .a_op         (a_q_ff),
      .b_op         (b_q_ff),
      .sat_value    (sat_value),
      .sat_overflow (sat_overflow)
   );

   // Result register, loaded once the sum is complete.
   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_value_ff <= sat_value;
         rsp_ovf_ff   <= sat_overflow;
         rsp_row_ff   <= row_ff;
         rsp_col_ff   <= col_ff;
         rsp_last_ff  <= (row_ff == DIM_LAST) && (col_ff == DIM_LAST);
      end
   end

   assign rsp_tvalid = (state_ff == ST_OUT);
   assign rsp_tdata  = {4'b0000, INDEX_BITS'(rsp_col_ff), INDEX_BITS'(rsp_row_ff),
                        ELEM_BITS'(rsp_value_ff)};
   assign rsp_tuser  = rsp_ovf_ff;
   assign rsp_tlast  = rsp_last_ff;

`ifndef SYNTH
   // Input and output are never open at the same time.
   a_one_side: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input ready while a result is offered");

   // After the final transaction of a product the block loads a fresh left matrix.
   a_restart: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> req_tready && (load_cnt_ff == '0))
      else $error("no restart after the last product element");

   // A saturated element carries one of the two limits.
   a_sat_limit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |->
         (rsp_tdata[ELEM_BITS-1:0] == SAT_MAX32) || (rsp_tdata[ELEM_BITS-1:0] == SAT_MIN32))
      else $error("overflow flagged on an unsaturated value");

   // Operands reach the multiplier only in the cycle after a read issued by the sequencer.
   a_read_issue: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> $past(state_ff == ST_MAC))
      else $error("operand read outside the accumulate phase");
`endif

endmodule

// ----- src/m4mul_mac.sv -----
// Shared multiply-accumulate unit with truncating shift and saturation.
module m4mul_mac #(
   parameter int DIM       = 4,
   parameter int FRAC_BITS = 16,
   parameter int WORD_BITS = 32
) (
   input  logic                        clock,
   input  logic                        reset,
   input  m4mul_pkg::mac_ctl_type      ctl,
   input  logic signed [WORD_BITS-1:0] a_op,
   input  logic signed [WORD_BITS-1:0] b_op,
   output logic signed [WORD_BITS-1:0] sat_value,
   output logic                        sat_overflow
);
   import m4mul_pkg::*;

   localparam int PROD_W = 2 * WORD_BITS;
   localparam int ACC_W  = PROD_W + $clog2(DIM);
   localparam int HI_W   = ACC_W - WORD_BITS + 1;

   logic signed [PROD_W-1:0] prod_ff;
   logic signed [PROD_W-1:0] prod_in;
   logic                     prod_vld_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  acc_in;
   logic signed [ACC_W-1:0]  shifted;
   logic [HI_W-1:0]          hi_bits;
   logic                     fits;
   logic                     neg;

   // Multiplier stage, registered before the adder.
   assign prod_in = a_op * b_op;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_vld_ff <= 1'b0;
      end else begin
         prod_vld_ff <= ctl.valid;
      end
      prod_ff <= prod_in;
   end

   // Accumulator: cleared at the start of each sum, adds one product a cycle while products are valid.
   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   // Drop the fraction bits and clamp the sum to the word range.
   assign shifted = acc_ff >>> FRAC_BITS;
   assign hi_bits = shifted[ACC_W-1:WORD_BITS-1];
   assign fits    = (&hi_bits) | ~(|hi_bits);
   assign neg     = acc_ff[ACC_W-1];

   always_comb begin
      if (fits) begin
         sat_value = shifted[WORD_BITS-1:0];
      end else if (neg) begin
         sat_value = {1'b1, {(WORD_BITS-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(WORD_BITS-1){1'b1}}};
      end
      sat_overflow = ~fits;
   end

endmodule

// ----- dv/matrix4_multiply_unit_tb.sv -----
// Self-checking testbench for the 4x4 fixed-point matrix multiply unit.
`timescale 1ns / 100ps

module matrix4_multiply_unit_tb;

   import m4mul_pkg::*;

   // Fixed-point constants used by the stimulus and the saturation check.
   localparam logic [31:0] ELEM_MIN = 32'h8000_0000;
   localparam logic [31:0] ELEM_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] ELEM_ONE = 32'h0001_0000;
   localparam logic [31:0] ELEM_MINUS_ONE = 32'hFFFF_0000;
   localparam logic signed [67:0] SUM_MAX = 68'sh0_0000_0000_7FFF_FFFF;
   localparam logic signed [67:0] SUM_MIN = -68'sh0_0000_0000_8000_0000;
   localparam int CELLS = 16;
   localparam int SET_SIZE = 2 * CELLS;
   localparam int RANDOM_SETS = 6;
   localparam int HOLD_CYCLES = 400;
   localparam int SETTLE_CYCLES = 150;
   localparam int CYCLE_LIMIT = 60000;

   // Kinds of content for the random matrix pairs.
   typedef enum int {
      CONTENT_WIDE,
      CONTENT_SMALL,
      CONTENT_EXTREME,
      CONTENT_MIXED
   } content_mode_type;

   // One product element as the block should emit it.
   typedef struct packed {
      logic [31:0] product;
      logic [1:0]  row;
      logic [1:0]  col;
      logic        overflow;
      logic        last;
   } product_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [ELEM_BITS-1:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;

   logic [31:0] element_queue[$];
   product_item_type expected_products[$];
   logic [31:0] left_cells[CELLS];
   logic [31:0] right_cells[CELLS];
   int loaded_count = 0;
   int elements_accepted = 0;
   int products_checked = 0;
   int saturated_seen = 0;
   int mismatch_count = 0;
   int hold_left = 0;
   bit hold_started = 1'b0;
   int cycle_count = 0;

   matrix4_multiply_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #2 clock = ~clock;

   // Forms the whole product from the two stored matrices and queues its elements.
   function automatic void predict_matrix_product();
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic signed [63:0] term;
      logic signed [67:0] sum;
      logic signed [67:0] scaled;
      product_item_type item;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            sum = '0;
            for (int k = 0; k < 4; k++) begin
               a = left_cells[i * 4 + k];
               b = right_cells[k * 4 + j];
               term = a * b;
               sum = sum + term;
            end
            // The shift truncates towards minus infinity, then the value is clamped.
            scaled = sum >>> 16;
            item.overflow = 1'b1;
            if (scaled > SUM_MAX) begin
               item.product = ELEM_MAX;
            end else if (scaled < SUM_MIN) begin
               item.product = ELEM_MIN;
            end else begin
               item.product = scaled[31:0];
               item.overflow = 1'b0;
            end
            item.row = 2'(i);
            item.col = 2'(j);
            item.last = (i == 3) && (j == 3);
            expected_products.push_back(item);
         end
      end
   endfunction

   // Stores one accepted element; the last element of the right matrix triggers a product.
   function automatic void absorb_element(logic [31:0] element);
      if (loaded_count < CELLS) begin
         left_cells[loaded_count] = element;
      end else begin
         right_cells[loaded_count - CELLS] = element;
      end
      loaded_count++;
      elements_accepted++;
      if (loaded_count == SET_SIZE) begin
         predict_matrix_product();
         loaded_count = 0;
      end
   endfunction

   function automatic void compare_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, exp, act);
         mismatch_count++;
      end
   endfunction

   // Compares one product transaction with the oldest expected element.
   function automatic void check_product();
      product_item_type exp;
      if (expected_products.size() == 0) begin
         $error("product transaction with none expected: data 0x%0h", rsp_tdata);
         mismatch_count++;
      end else begin
         exp = expected_products.pop_front();
         compare_field("product", exp.product, rsp_tdata[31:0]);
         compare_field("row_index", 32'(exp.row), 32'(rsp_tdata[33:32]));
         compare_field("col_index", 32'(exp.col), 32'(rsp_tdata[35:34]));
         compare_field("padding", 32'd0, 32'(rsp_tdata[39:36]));
         compare_field("overflow", 32'(exp.overflow), 32'(rsp_tuser));
         compare_field("last", 32'(exp.last), 32'(rsp_tlast));
         if (exp.overflow) saturated_seen++;
      end
      products_checked++;
   endfunction

   // Idle rates by phase: sender busy then sparse, receiver the other way round, then none.
   function automatic int sender_idle_pct();
      if (elements_accepted < 96) return 32;
      if (elements_accepted < 160) return 73;
      return 0;
   endfunction

   function automatic int receiver_idle_pct();
      if (products_checked < 48) return 73;
      if (products_checked < 80) return 32;
      return 0;
   endfunction

   function automatic logic [31:0] random_element(content_mode_type mode);
      int value;
      case (mode)
         CONTENT_WIDE: begin
            return $urandom();
         end
         CONTENT_SMALL: begin
            // Roughly -3.0 to +3.0 in Q16.16.
            value = int'($urandom_range(393216)) - 196608;
            return value;
         end
         CONTENT_EXTREME: begin
            case ($urandom_range(5))
               0: return ELEM_MIN;
               1: return ELEM_MAX;
               2: return ELEM_MIN + $urandom_range(255);
               3: return ELEM_MAX - $urandom_range(255);
               4: return ELEM_ONE;
               default: return ELEM_MINUS_ONE;
            endcase
         end
         default: begin
            return random_element(content_mode_type'($urandom_range(2)));
         end
      endcase
   endfunction

   // Driver: offers elements from the queue and updates the prediction on acceptance.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) absorb_element(req_tdata);
         if (!req_tvalid || req_tready) begin
            if (element_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct()) begin
               req_tvalid <= 1'b1;
               req_tdata <= element_queue.pop_front();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Monitor: checks product transactions and decides ready, with one long hold-off.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_product();
         if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (!hold_started && products_checked == 32 && rsp_tvalid) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_idle_pct());
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timed out after %0d cycles with %0d products outstanding.",
                  cycle_count, expected_products.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   // Stimulus and end of run.
   initial begin
      logic [31:0] directed_set[SET_SIZE];
      content_mode_type mode;
      // Left rows: all minimum, all maximum, an identity row, tiny and half values.
      // Right column 0 is all minimum, so the first two rows saturate both ways;
      // row 3 with column 1 gives a small negative sum that truncates towards minus infinity.
      directed_set = '{
         ELEM_MIN, ELEM_MIN, ELEM_MIN, ELEM_MIN,
         ELEM_MAX, ELEM_MAX, ELEM_MAX, ELEM_MAX,
         ELEM_ONE, 32'h0, 32'h0, 32'h0,
         32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_8000, ELEM_MINUS_ONE,
         ELEM_MIN, 32'h0000_0001, ELEM_ONE, ELEM_MAX,
         ELEM_MIN, 32'h0, 32'h0, ELEM_MAX,
         ELEM_MIN, 32'h0, ELEM_MAX, ELEM_MIN,
         ELEM_MIN, 32'h0, 32'h0, 32'h0
      };
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_set[n]) element_queue.push_back(directed_set[n]);

      for (int s = 0; s < RANDOM_SETS; s++) begin
         // Before the fifth random pair the sender waits for the block to drain.
         if (s == 4) begin
            while (element_queue.size() > 0 || req_tvalid || expected_products.size() > 0)
               @(posedge clock);
         end
         if (s == 0) mode = CONTENT_WIDE;
         else if (s == 1) mode = CONTENT_EXTREME;
         else mode = content_mode_type'($urandom_range(3));
         for (int n = 0; n < SET_SIZE; n++) element_queue.push_back(random_element(mode));
      end

      while (element_queue.size() > 0 || req_tvalid) @(posedge clock);
      while (expected_products.size() > 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Loaded %0d elements as %0d matrix pairs; checked %0d product elements.",
               elements_accepted, elements_accepted / SET_SIZE, products_checked);
      $display("%0d of them saturated; %0d field mismatches found.",
               saturated_seen, mismatch_count);
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
